/* rtl/ped_pkg.sv */
// Shared constants, codes and types of the packet energy and power meter.
package ped_pkg;

   localparam int SAMPLE_BITS     = 16;
   localparam int SQ_BITS         = 2 * SAMPLE_BITS;
   localparam int ENERGY_BITS     = 44;
   localparam int POWER_BITS      = 16;
   localparam int STATUS_BITS     = 2;
   localparam int MAX_LEN_DEFAULT = 4096;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = 2;
   localparam int QUEUE_CNT_BITS  = 3;

   localparam int POS_BITS        = 6;
   localparam int LOG_FRAC_BITS   = 16;
   localparam int LOG_BITS        = POS_BITS + LOG_FRAC_BITS;
   localparam int MANT_BITS       = 32;
   localparam int STEP_BITS       = 4;
   localparam int NORM_TOP        = ENERGY_BITS - 1;
   localparam int DIFF_BITS       = 24;
   localparam int COEF_BITS       = 19;
   localparam int PROD_BITS       = 43;
   localparam int ROUND_SHIFT     = 24;
   localparam int RESULT_BITS     = PROD_BITS - ROUND_SHIFT;

   localparam logic signed [COEF_BITS-1:0] DB_PER_LOG2_Q16 = 19'sd197283;
   localparam logic signed [DIFF_BITS-1:0] FULL_SCALE_LOG  =
      DIFF_BITS'(2 * (SAMPLE_BITS - 1) * 65536);
   localparam logic signed [PROD_BITS-1:0] ROUND_HALF      = 43'sd8388608;

   localparam logic [ENERGY_BITS-1:0]       ENERGY_MAX = '1;
   localparam logic signed [POWER_BITS-1:0] POWER_MIN  = 16'sh8000;
   localparam logic signed [POWER_BITS-1:0] POWER_MAX  = 16'sh7fff;

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO     = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic rd_valid;
      logic wr_room;
   } ped_queue_stat_type;

endpackage

/* rtl/ped_channels_if.sv */
// Valid/ready channel interfaces for samples and packet results.
interface ped_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ped_pkg::SAMPLE_BITS-1:0] sample_i;
   logic signed [ped_pkg::SAMPLE_BITS-1:0] sample_q;
   logic                                last_sample;

   modport source (output valid, sample_i, sample_q, last_sample, input ready);
   modport sink   (input valid, sample_i, sample_q, last_sample, output ready);
endinterface

interface ped_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [ped_pkg::ENERGY_BITS-1:0]       energy;
   logic signed [ped_pkg::POWER_BITS-1:0] power_db;
   logic [ped_pkg::STATUS_BITS-1:0]       status;

   modport source (output valid, energy, power_db, status, input ready);
   modport sink   (input valid, energy, power_db, status, output ready);
endinterface

/* rtl/ped_front.sv */
// Front end: accepts samples, squares them and accumulates packet energy and count.
module ped_front #(
   parameter int MAX_LEN = ped_pkg::MAX_LEN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   ped_req_if.sink                           req_bus,
   input  ped_pkg::ped_queue_stat_type       stat,
   output logic                              push,
   output logic [ped_pkg::ENERGY_BITS-1:0]   push_energy,
   output logic [$clog2(MAX_LEN+1)-1:0]      push_count,
   output logic                              push_ovf
);
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_LEN);

   logic                              accept;
   logic                              counted;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in, cnt_next;
   logic                              ovf_ff, ovf_in, ovf_next;
   logic signed [ped_pkg::SQ_BITS-1:0] prod_i, prod_q;
   logic [ped_pkg::SQ_BITS-1:0]       sq;

   logic                              a_valid_ff;
   logic                              a_last_ff;
   logic                              a_counted_ff;
   logic [ped_pkg::SQ_BITS-1:0]       a_sq_ff;
   logic [CNT_W-1:0]                  a_cnt_ff;
   logic                              a_ovf_ff;

   logic [ped_pkg::ENERGY_BITS-1:0]   energy_ff, energy_in, energy_next;
   logic [ped_pkg::ENERGY_BITS:0]     sum_wide;

   assign req_bus.ready = stat.wr_room;
   assign accept        = req_bus.valid & req_bus.ready;
   assign counted       = (cnt_ff != LIMIT);

   assign prod_i = req_bus.sample_i * req_bus.sample_i;
   assign prod_q = req_bus.sample_q * req_bus.sample_q;
   assign sq     = $unsigned(prod_i) + $unsigned(prod_q);

   always_comb begin
      cnt_next = counted ? cnt_ff + CNT_W'(1) : cnt_ff;
      ovf_next = ovf_ff | ~counted;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_bus.last_sample) begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            cnt_in = cnt_next;
            ovf_in = ovf_next;
         end
      end
   end

   always_comb begin
      sum_wide = {1'b0, energy_ff} + (ped_pkg::ENERGY_BITS+1)'(a_sq_ff);
      if (!a_counted_ff) begin
         energy_next = energy_ff;
      end else if (sum_wide[ped_pkg::ENERGY_BITS]) begin
         energy_next = ped_pkg::ENERGY_MAX;
      end else begin
         energy_next = sum_wide[ped_pkg::ENERGY_BITS-1:0];
      end
      energy_in = energy_ff;
      if (a_valid_ff) begin
         energy_in = a_last_ff ? '0 : energy_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         ovf_ff     <= 1'b0;
         a_valid_ff <= 1'b0;
         energy_ff  <= '0;
      end else begin
         cnt_ff     <= cnt_in;
         ovf_ff     <= ovf_in;
         a_valid_ff <= accept;
         energy_ff  <= energy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_last_ff    <= req_bus.last_sample;
         a_counted_ff <= counted;
         a_sq_ff      <= sq;
         a_cnt_ff     <= cnt_next;
         a_ovf_ff     <= ovf_next;
      end
   end

   assign push        = a_valid_ff & a_last_ff;
   assign push_energy = energy_next;
   assign push_count  = a_cnt_ff;
   assign push_ovf    = a_ovf_ff;

endmodule

/* rtl/ped_queue.sv */
// Short queue of closed packets between the front and back ends.
module ped_queue #(
   parameter int WIDTH = ped_pkg::ENERGY_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [WIDTH-1:0]            wr_data,
   input  logic                        rd_en,
   output logic [WIDTH-1:0]            rd_data,
   output ped_pkg::ped_queue_stat_type stat
);
   logic [WIDTH-1:0]                     mem [ped_pkg::QUEUE_DEPTH];
   logic [ped_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [ped_pkg::QUEUE_CNT_BITS-1:0]   level_ff, level_in;
   logic [WIDTH-1:0]                     rd_data_ff;

   always_comb begin
      level_in = level_ff;
      if (wr_en && !rd_en) begin
         level_in = level_ff + ped_pkg::QUEUE_CNT_BITS'(1);
      end else if (!wr_en && rd_en) begin
         level_in = level_ff - ped_pkg::QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + ped_pkg::QUEUE_PTR_BITS'(1);
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + ped_pkg::QUEUE_PTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign rd_data       = rd_data_ff;
   assign stat.rd_valid = (level_ff != '0);
   assign stat.wr_room  =
      (level_ff <= ped_pkg::QUEUE_CNT_BITS'(ped_pkg::QUEUE_DEPTH - 2));

endmodule

/* rtl/ped_back.sv */
// Back end: log2 of energy and count, dB scaling, rounding and result register.
module ped_back #(
   parameter int MAX_LEN = ped_pkg::MAX_LEN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ped_pkg::ped_queue_stat_type       stat,
   output logic                              rd_en,
   input  logic [ped_pkg::ENERGY_BITS-1:0]   rd_energy,
   input  logic [$clog2(MAX_LEN+1)-1:0]      rd_count,
   input  logic                              rd_ovf,
   ped_rsp_if.source                         rsp_bus
);
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int EB    = ped_pkg::ENERGY_BITS;
   localparam logic signed [ped_pkg::RESULT_BITS-1:0] SAT_LO =
      ped_pkg::RESULT_BITS'(ped_pkg::POWER_MIN);
   localparam logic signed [ped_pkg::RESULT_BITS-1:0] SAT_HI =
      ped_pkg::RESULT_BITS'(ped_pkg::POWER_MAX);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_LOAD = 7'b0000010,
      ST_NORM = 7'b0000100,
      ST_FRAC = 7'b0001000,
      ST_DIFF = 7'b0010000,
      ST_MUL  = 7'b0100000,
      ST_DONE = 7'b1000000
   } ped_state_type;

   ped_state_type                          state_ff, state_in;
   logic [EB-1:0]                          energy_ff;
   logic [CNT_W-1:0]                       cnt_ff;
   logic                                   ovf_ff;
   logic                                   zero_ff;
   logic                                   phase_ff;
   logic [EB-1:0]                          norm_ff;
   logic [ped_pkg::POS_BITS-1:0]           pos_ff;
   logic [ped_pkg::MANT_BITS-1:0]          mant_ff;
   logic [ped_pkg::LOG_FRAC_BITS-1:0]      frac_ff;
   logic [ped_pkg::STEP_BITS-1:0]          step_ff;
   logic [ped_pkg::LOG_BITS-1:0]           lg_e_ff, lg_c_ff;
   logic signed [ped_pkg::DIFF_BITS-1:0]   diff_ff;
   logic signed [ped_pkg::PROD_BITS-1:0]   prod_ff;

   logic                                   out_valid_ff;
   logic [EB-1:0]                          out_energy_ff;
   logic signed [ped_pkg::POWER_BITS-1:0]  out_power_ff;
   logic [ped_pkg::STATUS_BITS-1:0]        out_status_ff;

   logic [2*ped_pkg::MANT_BITS-1:0]        mant_sq;
   logic [ped_pkg::MANT_BITS:0]            mant_hi;
   logic [ped_pkg::LOG_FRAC_BITS-1:0]      frac_new;
   logic signed [ped_pkg::PROD_BITS-1:0]   rounded;
   logic signed [ped_pkg::RESULT_BITS-1:0] scaled;
   logic signed [ped_pkg::POWER_BITS-1:0]  power_sat;
   logic [ped_pkg::STATUS_BITS-1:0]        status_c;
   logic                                   out_free;
   logic                                   load_out;

   assign mant_sq  = mant_ff * mant_ff;
   assign mant_hi  = mant_sq[2*ped_pkg::MANT_BITS-1:ped_pkg::MANT_BITS-1];
   assign frac_new = {frac_ff[ped_pkg::LOG_FRAC_BITS-2:0], mant_hi[ped_pkg::MANT_BITS]};

   assign rounded = prod_ff + ped_pkg::ROUND_HALF;
   assign scaled  = ped_pkg::RESULT_BITS'(rounded >>> ped_pkg::ROUND_SHIFT);

   always_comb begin
      if (zero_ff || scaled < SAT_LO) begin
         power_sat = ped_pkg::POWER_MIN;
      end else if (scaled > SAT_HI) begin
         power_sat = ped_pkg::POWER_MAX;
      end else begin
         power_sat = ped_pkg::POWER_BITS'(scaled);
      end
      if (ovf_ff) begin
         status_c = ped_pkg::STATUS_OVERFLOW;
      end else if (energy_ff == '0) begin
         status_c = ped_pkg::STATUS_ZERO;
      end else begin
         status_c = ped_pkg::STATUS_OK;
      end
   end

   assign out_free = ~out_valid_ff | rsp_bus.ready;
   assign load_out = (state_ff == ST_DONE) & out_free;
   assign rd_en    = (state_ff == ST_IDLE) & stat.rd_valid;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (stat.rd_valid) state_in = ST_LOAD;
         ST_LOAD: begin
            if (rd_energy == '0 || rd_count == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: if (norm_ff[EB-1]) state_in = ST_FRAC;
         ST_FRAC: begin
            if (step_ff == '1) begin
               state_in = phase_ff ? ST_DIFF : ST_NORM;
            end
         end
         ST_DIFF: state_in = ST_MUL;
         ST_MUL:  state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_LOAD: begin
            energy_ff <= rd_energy;
            cnt_ff    <= rd_count;
            ovf_ff    <= rd_ovf;
            zero_ff   <= (rd_energy == '0) || (rd_count == '0);
            norm_ff   <= rd_energy;
            pos_ff    <= ped_pkg::POS_BITS'(EB - 1);
            phase_ff  <= 1'b0;
         end
         ST_NORM: begin
            if (norm_ff[EB-1]) begin
               mant_ff <= norm_ff[EB-1:EB-ped_pkg::MANT_BITS];
               frac_ff <= '0;
               step_ff <= '0;
            end else if (norm_ff[EB-1:EB-4] == 4'd0) begin
               norm_ff <= {norm_ff[EB-5:0], 4'd0};
               pos_ff  <= pos_ff - ped_pkg::POS_BITS'(4);
            end else begin
               norm_ff <= {norm_ff[EB-2:0], 1'b0};
               pos_ff  <= pos_ff - ped_pkg::POS_BITS'(1);
            end
         end
         ST_FRAC: begin
            frac_ff <= frac_new;
            step_ff <= step_ff + ped_pkg::STEP_BITS'(1);
            mant_ff <= mant_hi[ped_pkg::MANT_BITS] ? mant_hi[ped_pkg::MANT_BITS:1]
                                                   : mant_hi[ped_pkg::MANT_BITS-1:0];
            if (step_ff == '1) begin
               if (phase_ff) begin
                  lg_c_ff <= {pos_ff, frac_new};
               end else begin
                  lg_e_ff  <= {pos_ff, frac_new};
                  norm_ff  <= EB'(cnt_ff);
                  pos_ff   <= ped_pkg::POS_BITS'(EB - 1);
                  phase_ff <= 1'b1;
               end
            end
         end
         ST_DIFF: begin
            diff_ff <= $signed({2'b00, lg_e_ff}) - $signed({2'b00, lg_c_ff})
                       - ped_pkg::FULL_SCALE_LOG;
         end
         ST_MUL: begin
            prod_ff <= diff_ff * ped_pkg::DB_PER_LOG2_Q16;
         end
         default: begin
         end
      endcase
      if (load_out) begin
         out_energy_ff <= energy_ff;
         out_power_ff  <= power_sat;
         out_status_ff <= status_c;
      end
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.energy   = out_energy_ff;
   assign rsp_bus.power_db = out_power_ff;
   assign rsp_bus.status   = out_status_ff;

endmodule

/* rtl/packet_energy_power_db.sv */
// Top level of the packet energy and mean power (dBFS) meter.
//
//   channel   dir  handshake      payload
//   req_bus   in   valid/ready    sample_i, sample_q, last_sample
//   rsp_bus   out  valid/ready    energy, power_db, status
//
// Samples are taken one per clock while the queue has room. A packet result passes, after its
// last sample, through the front-end registers, the queue and two log2 passes of 1 to 14 normalize
// steps and 16 fraction steps each, then difference, scaling and output; zero energy skips the passes.
// The back end takes the next packet from the queue only after the last result is in its output register.
// Up to four closed packets wait in the queue; req_bus.ready drops once three are queued.
// Synchronous active-high reset clears counters, energy, queue and state.
module packet_energy_power_db #(
   parameter int MAX_LEN = ped_pkg::MAX_LEN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ped_req_if.sink    req_bus,
   ped_rsp_if.source  rsp_bus
);
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int QW    = ped_pkg::ENERGY_BITS + CNT_W + 1;

   ped_pkg::ped_queue_stat_type     stat;
   logic                            push;
   logic [ped_pkg::ENERGY_BITS-1:0] push_energy;
   logic [CNT_W-1:0]                push_count;
   logic                            push_ovf;
   logic                            rd_en;
   logic [QW-1:0]                   rd_data;

   ped_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .stat        (stat),
      .push        (push),
      .push_energy (push_energy),
      .push_count  (push_count),
      .push_ovf    (push_ovf)
   );

   ped_queue #(.WIDTH(QW)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data ({push_energy, push_count, push_ovf}),
      .rd_en   (rd_en),
      .rd_data (rd_data),
      .stat    (stat)
   );

   ped_back #(.MAX_LEN(MAX_LEN)) u_back (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .rd_en     (rd_en),
      .rd_energy (rd_data[QW-1:CNT_W+1]),
      .rd_count  (rd_data[CNT_W:1]),
      .rd_ovf    (rd_data[0]),
      .rsp_bus   (rsp_bus)
   );

endmodule

/* tb/tb_packet_energy_power_db.sv */
// Testbench for the packet energy and mean power meter: predicted results vs. the block.
`timescale 1ns / 1ps

module tb_packet_energy_power_db;

   localparam int  MAX_SAMPLES       = ped_pkg::MAX_LEN_DEFAULT;
   localparam int  FULL_SCALE_Q16    = 2 * (ped_pkg::SAMPLE_BITS - 1) * 65536;
   localparam longint DB_PER_OCTAVE  = 197283;
   localparam int  LONG_HOLD         = 400;
   localparam int  QUIET_LIMIT       = 5000;
   localparam int  DRAIN_CYCLES      = 100;
   localparam int  RANDOM_ITEMS      = 1750;
   localparam int  CALM_ITEMS        = 300;

   typedef struct packed {
      logic [ped_pkg::ENERGY_BITS-1:0]       energy;
      logic signed [ped_pkg::POWER_BITS-1:0] power_db;
      logic [ped_pkg::STATUS_BITS-1:0]       status;
   } packet_result_type;

   typedef enum {FULL_RANGE, TINY, SILENT, RAIL} amplitude_type;

   class power_meter_scoreboard;
      logic [ped_pkg::ENERGY_BITS-1:0] energy_acc;
      int unsigned                     sample_total;
      bit                              length_exceeded;
      packet_result_type               expected_q[$];
      int                              mismatches;

      function new();
         energy_acc      = '0;
         sample_total    = 0;
         length_exceeded = 1'b0;
         mismatches      = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function longint log2_q16(logic [63:0] x);
         int          p;
         int          k;
         logic [63:0] m;
         longint      frac;
         p = 63;
         while (p > 0 && x[p] == 1'b0)
            p--;
         if (p >= 31)
            m = x >> (p - 31);
         else
            m = x << (31 - p);
         frac = 0;
         for (k = 0; k < 16; k++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
               frac = frac | 1;
               m = m >> 1;
            end
         end
         return longint'(p) * 65536 + frac;
      endfunction

      function void note_sample(logic signed [ped_pkg::SAMPLE_BITS-1:0] si,
                                logic signed [ped_pkg::SAMPLE_BITS-1:0] sq,
                                logic closing);
         logic [63:0]       add_term;
         longint            d;
         longint            t;
         longint            r;
         packet_result_type res;
         if (sample_total >= MAX_SAMPLES) begin
            length_exceeded = 1'b1;
         end else begin
            add_term = longint'(si) * longint'(si) + longint'(sq) * longint'(sq);
            if (add_term > 64'(ped_pkg::ENERGY_MAX) - 64'(energy_acc))
               energy_acc = ped_pkg::ENERGY_MAX;
            else
               energy_acc = energy_acc + add_term[ped_pkg::ENERGY_BITS-1:0];
            sample_total++;
         end
         if (!closing)
            return;
         if (energy_acc == '0) begin
            res.power_db = ped_pkg::POWER_MIN;
         end else begin
            d = log2_q16(64'(energy_acc)) - log2_q16(64'(sample_total))
                - FULL_SCALE_Q16;
            t = d * DB_PER_OCTAVE + (longint'(1) << 23);
            r = t >>> 24;
            if (r < -32768)
               r = -32768;
            if (r > 32767)
               r = 32767;
            res.power_db = r[ped_pkg::POWER_BITS-1:0];
         end
         if (length_exceeded)
            res.status = ped_pkg::STATUS_OVERFLOW;
         else if (energy_acc == '0)
            res.status = ped_pkg::STATUS_ZERO;
         else
            res.status = ped_pkg::STATUS_OK;
         res.energy = energy_acc;
         expected_q.push_back(res);
         energy_acc      = '0;
         sample_total    = 0;
         length_exceeded = 1'b0;
      endfunction

      function void check_result(logic [ped_pkg::ENERGY_BITS-1:0] e,
                                 logic signed [ped_pkg::POWER_BITS-1:0] p,
                                 logic [ped_pkg::STATUS_BITS-1:0] s);
         packet_result_type want;
         if (expected_q.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected packet result: energy %0d power_db %0d status %0d",
                        e, p, s);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         if (want.energy !== e || want.power_db !== p || want.status !== s) begin
            if (mismatches < 10)
               $display("packet result mismatch (expected/actual):",
                        " energy %0d/%0d", want.energy, e,
                        " power_db %0d/%0d", want.power_db, p,
                        " status %0d/%0d", want.status, s);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ped_req_if req_bus ();
   ped_rsp_if rsp_bus ();

   packet_energy_power_db DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   power_meter_scoreboard meter = new();

   bit sender_gaps   = 1'b1;
   bit receiver_gaps = 1'b1;
   bit hold_request  = 1'b0;
   int samples_sent  = 0;
   int quiet_cycles  = 0;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            meter.check_result(rsp_bus.energy, rsp_bus.power_db, rsp_bus.status);
         if (hold_request) begin
            stall_left = LONG_HOLD;
            hold_request = 1'b0;
         end else if (stall_left == 0 && receiver_gaps && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic logic signed [ped_pkg::SAMPLE_BITS-1:0] pick_sample(
      amplitude_type amp);
      case (amp)
         TINY:    return ped_pkg::SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
         SILENT:  return '0;
         RAIL: begin
            case ($urandom_range(0, 3))
               0:       return 16'sh8000;
               1:       return 16'sh8001;
               2:       return 16'sh7fff;
               default: return 16'sh7ffe;
            endcase
         end
         default: return ped_pkg::SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic signed [ped_pkg::SAMPLE_BITS-1:0] si,
                              input logic signed [ped_pkg::SAMPLE_BITS-1:0] sq,
                              input logic closing);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.sample_i    <= si;
      req_bus.sample_q    <= sq;
      req_bus.last_sample <= closing;
      do @(posedge clock); while (!req_bus.ready);
      meter.note_sample(si, sq, closing);
      samples_sent++;
   endtask

   task automatic send_packet(input int len, input amplitude_type amp);
      for (int n = 0; n < len; n++)
         send_sample(pick_sample(amp), pick_sample(amp), n == len - 1);
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (meter.pending() != 0)
         @(posedge clock);
   endtask

   initial begin
      int            len;
      amplitude_type amp;
      req_bus.valid       <= 1'b0;
      req_bus.sample_i    <= '0;
      req_bus.sample_q    <= '0;
      req_bus.last_sample <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_sample(16'sh8000, 16'sh8000, 1'b1);
      send_sample(16'sh7fff, 16'sh7fff, 1'b1);
      send_sample(16'sh0000, 16'sh0000, 1'b1);
      send_sample(16'sh0001, 16'sh0000, 1'b1);
      send_sample(16'sh0000, 16'shffff, 1'b1);
      send_sample(16'sh8000, 16'sh0000, 1'b1);
      send_sample(16'sh7fff, 16'sh8000, 1'b1);
      send_packet(3, SILENT);
      send_sample(16'sh0001, 16'sh0001, 1'b0);
      send_sample(16'shffff, 16'shffff, 1'b1);
      send_packet(4, RAIL);
      send_packet(5, FULL_RANGE);
      wait_for_drain();

      // hold the result side while short packets back up the queue
      hold_request = 1'b1;
      send_packet(1, FULL_RANGE);
      repeat (12) send_packet(1, TINY);
      wait_for_drain();

      samples_sent = 0;
      while (samples_sent < RANDOM_ITEMS) begin
         if (samples_sent >= RANDOM_ITEMS - CALM_ITEMS) begin
            sender_gaps   = 1'b0;
            receiver_gaps = 1'b0;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = $urandom_range(1, 12);
            6, 7, 8:          len = $urandom_range(13, 40);
            default:          len = $urandom_range(41, 150);
         endcase
         case ($urandom_range(0, 9))
            0:       amp = SILENT;
            1:       amp = TINY;
            2:       amp = RAIL;
            default: amp = FULL_RANGE;
         endcase
         send_packet(len, amp);
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (meter.mismatches == 0 && meter.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* filelist.f */
rtl/ped_pkg.sv
rtl/ped_channels_if.sv
rtl/ped_front.sv
rtl/ped_queue.sv
rtl/ped_back.sv
rtl/packet_energy_power_db.sv
tb/tb_packet_energy_power_db.sv
